// ----- hw/rtl/plip_pkg.sv -----
// plip_pkg: shared constants for the piecewise linear interpolator
// opcodes, status codes, payload and register widths; no dependencies

package plip_pkg;

    localparam int unsigned VAL_W    = 32;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_VALUE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WRITE_OK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    localparam logic [0:0] REG_BREAKPOINT_COUNT = 1'b0;

endpackage

// ----- hw/rtl/plip_in_if.sv -----
// plip_in_if: input item channel, valid/ready with write or evaluate payload
// depends on plip_pkg

interface plip_in_if;
    import plip_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_W-1:0]         entry_index;
    logic signed [VAL_W-1:0]  x_value;
    logic signed [VAL_W-1:0]  y_value;

    modport source (output valid, opcode, entry_index, x_value, y_value, input ready);
    modport sink   (input valid, opcode, entry_index, x_value, y_value, output ready);
endinterface

// ----- hw/rtl/plip_out_if.sv -----
// plip_out_if: result channel, valid/ready with value and status payload
// depends on plip_pkg

interface plip_out_if;
    import plip_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  result_value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

// ----- hw/rtl/plip_ram.sv -----
// plip_ram: generic single write port, single read port ram with registered read
// no dependencies

module plip_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/piecewise_linear_interpolator.sv -----
// piecewise_linear_interpolator: breakpoint table with segment scan and lerp
// write item: result in the cycle after the transfer. evaluate: scans the stored
// breakpoints in order (up to MAX_POINTS) from one ram read port, then a multiply
// state, the bit-serial divider and a finish state
// one item at a time; next transfer the cycle after the result has been taken
// sync active-low reset: count 0, sequencer idle, output empty; table undefined

module piecewise_linear_interpolator #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    plip_in_if.sink                     i_item,
    plip_out_if.source                  o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [plip_pkg::ADDR_W-1:0] paddr,
    input  logic [plip_pkg::DATA_W-1:0] pwdata,
    output logic [plip_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import plip_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_POINTS);
    localparam int unsigned N_W = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [COUNT_W-1:0]      r_count;
    logic [AW-1:0]           r_idx, n_idx;
    logic signed [VAL_W-1:0] r_x, n_x;
    logic signed [VAL_W-1:0] r_x0, n_x0;
    logic signed [VAL_W-1:0] r_y0, n_y0;
    logic [VAL_W-1:0]        r_t, n_t;
    logic [VAL_W-1:0]        r_mag, n_mag;
    logic [VAL_W-1:0]        r_dx, n_dx;
    logic                    r_neg, n_neg;
    logic [2*VAL_W-1:0]      r_prod, n_prod;
    logic [VAL_W-1:0]        r_rem, n_rem;
    logic [5:0]              r_cnt, n_cnt;
    logic                    r_ovalid, n_ovalid;
    logic signed [VAL_W-1:0] r_result, n_result;
    logic [STATUS_W-1:0]     r_status, n_status;

    logic                    in_xfer, out_xfer, cfg_wr;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [2*VAL_W-1:0]      ram_wdata, ram_rdata;
    logic signed [VAL_W-1:0] cur_x, cur_y;
    logic [N_W-1:0]          n_pts;
    logic                    at_last;
    logic signed [VAL_W:0]   dy;
    logic [VAL_W:0]          rem_sh, rem_sub;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[ADDR_W-1:2] == REG_BREAKPOINT_COUNT)
                  ? DATA_W'(r_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_BREAKPOINT_COUNT) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign n_pts = (32'(r_count) > MAX_POINTS) ? N_W'(MAX_POINTS) : N_W'(r_count);

    // handshakes
    assign i_item.ready          = (r_state == S_IDLE) && !r_ovalid;
    assign in_xfer               = i_item.valid && i_item.ready;
    assign o_result.valid        = r_ovalid;
    assign o_result.result_value = r_result;
    assign o_result.status       = r_status;
    assign out_xfer              = r_ovalid && o_result.ready;

    // breakpoint table, x in the upper half
    assign ram_we    = in_xfer && (i_item.opcode == OP_WRITE)
                    && (32'(i_item.entry_index) < MAX_POINTS);
    assign ram_waddr = AW'(i_item.entry_index);
    assign ram_wdata = {i_item.x_value, i_item.y_value};
    assign ram_raddr = (r_state == S_IDLE) ? '0 : AW'(r_idx + 1'b1);

    plip_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_x   = ram_rdata[2*VAL_W-1:VAL_W];
    assign cur_y   = ram_rdata[VAL_W-1:0];
    assign at_last = (N_W'(r_idx) == n_pts - N_W'(1));
    assign dy      = {cur_y[VAL_W-1], cur_y} - {r_y0[VAL_W-1], r_y0};
    assign rem_sh  = {r_rem, r_prod[2*VAL_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dx};

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_x      = r_x;
        n_x0     = r_x0;
        n_y0     = r_y0;
        n_t      = r_t;
        n_mag    = r_mag;
        n_dx     = r_dx;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !out_xfer;
        n_result = r_result;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_x   = i_item.x_value;
                    n_idx = '0;
                    if (i_item.opcode == OP_WRITE) begin
                        n_ovalid = 1'b1;
                        n_result = '0;
                        n_status = ST_WRITE_OK;
                    end else if (n_pts == '0) begin
                        n_ovalid = 1'b1;
                        n_result = '0;
                        n_status = ST_EMPTY;
                    end else begin
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                n_x0  = cur_x;
                n_y0  = cur_y;
                n_idx = AW'(1);
                if (r_x <= cur_x || n_pts == N_W'(1)) begin
                    n_ovalid = 1'b1;
                    n_result = cur_y;
                    n_status = ST_VALUE;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_x0 <= r_x && r_x <= cur_x) begin
                    if (cur_x == r_x0) begin
                        n_ovalid = 1'b1;
                        n_result = r_y0;
                        n_status = ST_VALUE;
                        n_state  = S_IDLE;
                    end else begin
                        n_t     = VAL_W'(r_x - r_x0);
                        n_dx    = VAL_W'(cur_x - r_x0);
                        n_neg   = dy[VAL_W];
                        n_mag   = dy[VAL_W] ? VAL_W'(-dy) : VAL_W'(dy);
                        n_state = S_MUL;
                    end
                end else begin
                    n_x0 = cur_x;
                    n_y0 = cur_y;
                    if (at_last) begin
                        n_ovalid = 1'b1;
                        n_result = cur_y;
                        n_status = ST_VALUE;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = AW'(r_idx + 1'b1);
                    end
                end
            end
            S_MUL: begin
                n_prod  = r_t * r_mag;
                n_rem   = '0;
                n_cnt   = '1;
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (!rem_sub[VAL_W]) begin
                    n_rem  = rem_sub[VAL_W-1:0];
                    n_prod = {r_prod[2*VAL_W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[VAL_W-1:0];
                    n_prod = {r_prod[2*VAL_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_result = r_neg ? r_y0 - $signed(r_prod[VAL_W-1:0])
                                 : r_y0 + $signed(r_prod[VAL_W-1:0]);
                n_status = ST_VALUE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_idx    <= n_idx;
        r_x      <= n_x;
        r_x0     <= n_x0;
        r_y0     <= n_y0;
        r_t      <= n_t;
        r_mag    <= n_mag;
        r_dx     <= n_dx;
        r_neg    <= n_neg;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_result <= n_result;
        r_status <= n_status;
    end

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_item.opcode == OP_WRITE)
        |=> (o_result.valid && o_result.status == ST_WRITE_OK && o_result.result_value == '0))
        else $error("write transfer did not give a write status");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dx != '0))
        else $error("divider running with zero divisor");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == ST_EMPTY) |-> (o_result.result_value == '0))
        else $error("empty table status with nonzero value");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DIV) |-> !i_item.ready)
        else $error("input ready while an evaluation is in progress");

endmodule
